// ----- hw/rtl/bhml_pkg.sv -----
// Shared types, codes and constants for the byte handshake message link.
`timescale 1ns / 1ps
`default_nettype none
package bhml_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_BACKOFF_POLLS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAIL_LIMIT    = 1'd1;

   localparam logic [15:0] BACKOFF_POLLS_RESET = 16'd10000;
   localparam logic [7:0]  BAIL_LIMIT_RESET    = 8'd50;

   // Command codes on the request channel
   localparam logic [1:0] CMD_POLL     = 2'd0;
   localparam logic [1:0] CMD_START_RD = 2'd1;
   localparam logic [1:0] CMD_START_SD = 2'd2;
   localparam logic [1:0] CMD_INIT     = 2'd3;

   // Item classes after decode
   localparam logic [1:0] OP_POLL     = 2'd0;
   localparam logic [1:0] OP_START_RD = 2'd1;
   localparam logic [1:0] OP_START_SD = 2'd2;
   localparam logic [1:0] OP_INIT     = 2'd3;

   // Link control codes
   localparam logic [7:0] SYNC_RESET = 8'hF1;
   localparam logic [7:0] CODE_WRITE = 8'h02;
   localparam logic [7:0] CODE_READ  = 8'h06;

   // Phase codes
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_WAIT_R  = 4'd1;
   localparam logic [3:0] PH_WAIT_S  = 4'd2;
   localparam logic [3:0] PH_RD_HI   = 4'd3;
   localparam logic [3:0] PH_RD_LO   = 4'd4;
   localparam logic [3:0] PH_RD_BODY = 4'd5;
   localparam logic [3:0] PH_SD_HI   = 4'd6;
   localparam logic [3:0] PH_SD_LO   = 4'd7;
   localparam logic [3:0] PH_SD_BODY = 4'd8;

   // Status codes
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_DONE    = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [1:0]  op;
      logic        sync_hit;   // partner control reads the reset sync code
      logic [7:0]  tc_value;
      logic [7:0]  td_value;
      logic [7:0]  tx_byte;
      logic [15:0] send_length;
   } bhml_item_type;

endpackage
`default_nettype wire

// ----- hw/rtl/bhml_front.sv -----
// Front end: accepts request items, classifies them and pushes them to the queue.
`timescale 1ns / 1ps
`default_nettype none
module bhml_front (
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_cmd,
   input  wire logic [7:0]              req_tc_value,
   input  wire logic [7:0]              req_td_value,
   input  wire logic [7:0]              req_tx_byte,
   input  wire logic [15:0]             req_send_length,
   input  wire logic                    queue_full,
   output logic                         queue_push,
   output bhml_pkg::bhml_item_type      queue_item
);

   always_comb begin
      unique case (req_cmd)
         bhml_pkg::CMD_POLL:     queue_item.op = bhml_pkg::OP_POLL;
         bhml_pkg::CMD_START_RD: queue_item.op = bhml_pkg::OP_START_RD;
         bhml_pkg::CMD_START_SD: queue_item.op = bhml_pkg::OP_START_SD;
         bhml_pkg::CMD_INIT:     queue_item.op = bhml_pkg::OP_INIT;
         default:                queue_item.op = bhml_pkg::OP_POLL;
      endcase
      queue_item.sync_hit    = (req_tc_value == bhml_pkg::SYNC_RESET);
      queue_item.tc_value    = req_tc_value;
      queue_item.td_value    = req_td_value;
      queue_item.tx_byte     = req_tx_byte;
      queue_item.send_length = req_send_length;
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid & ~queue_full;

endmodule
`default_nettype wire

// ----- hw/rtl/bhml_queue.sv -----
// Short item queue between the front end and the link engine.
`timescale 1ns / 1ps
`default_nettype none
module bhml_queue #(
   parameter int DEPTH = bhml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire bhml_pkg::bhml_item_type push_item,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         pop_valid,
   output bhml_pkg::bhml_item_type      pop_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   bhml_pkg::bhml_item_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- hw/rtl/bhml_engine.sv -----
// Back end: link state machine, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module bhml_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [bhml_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bhml_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                 item_valid,
   input  wire bhml_pkg::bhml_item_type              item,
   output logic                                      item_pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_rc_write,
   output logic [7:0]                                rsp_rc_value,
   output logic                                      rsp_rd_write,
   output logic [7:0]                                rsp_rd_value,
   output logic                                      rsp_rx_valid,
   output logic [7:0]                                rsp_rx_byte,
   output logic                                      rsp_tx_taken,
   output logic [1:0]                                rsp_status,
   output logic [15:0]                               rsp_msg_length
);

   logic [15:0] backoff_polls_ff;
   logic [7:0]  bail_limit_ff;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  last_sync_ff, last_sync_in;
   logic [15:0] backoff_left_ff, backoff_left_in;
   logic [7:0]  bail_count_ff, bail_count_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] byte_count_ff, byte_count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rc_write_ff, rc_write_in;
   logic [7:0]  rc_value_ff, rc_value_in;
   logic        rd_write_ff, rd_write_in;
   logic [7:0]  rd_value_ff, rd_value_in;
   logic        rx_valid_ff, rx_valid_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic        tx_taken_ff, tx_taken_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] msg_length_ff;

   logic        fire;
   logic        done;
   logic        timeout;
   logic [8:0]  bail_next;
   logic [7:0]  code_rd;
   logic [7:0]  code_sd;
   logic [15:0] byte_count_inc;
   logic [15:0] length_lo;

   // An item runs when the result register is free or is being emptied.
   assign fire     = item_valid & (~rsp_valid_ff | ~rsp_stall);
   assign item_pop = fire;

   assign code_rd        = {7'd0, ~last_sync_ff[0]} | bhml_pkg::CODE_WRITE;
   assign code_sd        = {7'd0, ~last_sync_ff[0]} | bhml_pkg::CODE_READ;
   assign bail_next      = {1'b0, bail_count_ff} + 9'd1;
   assign byte_count_inc = byte_count_ff + 16'd1;
   assign length_lo      = length_ff | {8'd0, item.td_value};

   always_comb begin
      phase_in        = phase_ff;
      last_sync_in    = last_sync_ff;
      backoff_left_in = backoff_left_ff;
      bail_count_in   = bail_count_ff;
      length_in       = length_ff;
      byte_count_in   = byte_count_ff;
      rc_write_in     = 1'b0;
      rc_value_in     = 8'd0;
      rd_write_in     = 1'b0;
      rd_value_in     = 8'd0;
      rx_valid_in     = 1'b0;
      rx_byte_in      = 8'd0;
      tx_taken_in     = 1'b0;
      status_in       = bhml_pkg::ST_IDLE;
      done            = 1'b0;
      timeout         = 1'b0;

      unique case (item.op)
         bhml_pkg::OP_INIT: begin
            rd_write_in = 1'b1;
            rc_write_in = 1'b1;
            phase_in    = bhml_pkg::PH_IDLE;
         end
         bhml_pkg::OP_START_RD, bhml_pkg::OP_START_SD: begin
            phase_in        = (item.op == bhml_pkg::OP_START_RD) ?
                              bhml_pkg::PH_WAIT_R : bhml_pkg::PH_WAIT_S;
            last_sync_in    = 8'd0;
            backoff_left_in = backoff_polls_ff;
            bail_count_in   = 8'd0;
            byte_count_in   = 16'd0;
            length_in       = (item.op == bhml_pkg::OP_START_RD) ? 16'd0 : item.send_length;
         end
         default: begin
            unique case (phase_ff) inside
               bhml_pkg::PH_WAIT_R, bhml_pkg::PH_WAIT_S: begin
                  if (backoff_left_ff <= 16'd1) begin
                     backoff_left_in = 16'd1;
                     timeout         = (bail_next > {1'b0, bail_limit_ff});
                     bail_count_in   = bail_next[8] ? 8'hFF : bail_next[7:0];
                  end else begin
                     backoff_left_in = backoff_left_ff - 16'd1;
                  end
                  if (timeout) begin
                     phase_in = bhml_pkg::PH_IDLE;
                  end else if (item.sync_hit) begin
                     rc_write_in = 1'b1;
                     rc_value_in = bhml_pkg::SYNC_RESET;
                     if (phase_ff == bhml_pkg::PH_WAIT_R) begin
                        last_sync_in = bhml_pkg::CODE_WRITE + 8'd1;
                        phase_in     = bhml_pkg::PH_RD_HI;
                     end else begin
                        last_sync_in = bhml_pkg::CODE_READ + 8'd1;
                        phase_in     = bhml_pkg::PH_SD_HI;
                     end
                  end
               end
               bhml_pkg::PH_RD_HI, bhml_pkg::PH_RD_LO, bhml_pkg::PH_RD_BODY: begin
                  if (item.tc_value == code_rd) begin
                     last_sync_in = item.tc_value;
                     rc_write_in  = 1'b1;
                     rc_value_in  = item.tc_value;
                     if (phase_ff == bhml_pkg::PH_RD_HI) begin
                        length_in = {item.td_value, 8'd0};
                        phase_in  = bhml_pkg::PH_RD_LO;
                     end else if (phase_ff == bhml_pkg::PH_RD_LO) begin
                        length_in     = length_lo;
                        byte_count_in = 16'd0;
                        if (length_lo == 16'd0) begin
                           done = 1'b1;
                        end else begin
                           phase_in = bhml_pkg::PH_RD_BODY;
                        end
                     end else begin
                        rx_valid_in   = 1'b1;
                        rx_byte_in    = item.td_value;
                        byte_count_in = byte_count_inc;
                        done          = (byte_count_inc >= length_ff);
                     end
                  end
               end
               bhml_pkg::PH_SD_HI, bhml_pkg::PH_SD_LO, bhml_pkg::PH_SD_BODY: begin
                  if (item.tc_value == code_sd) begin
                     last_sync_in = item.tc_value;
                     rc_write_in  = 1'b1;
                     rc_value_in  = item.tc_value;
                     rd_write_in  = 1'b1;
                     if (phase_ff == bhml_pkg::PH_SD_HI) begin
                        rd_value_in = length_ff[15:8];
                        phase_in    = bhml_pkg::PH_SD_LO;
                     end else if (phase_ff == bhml_pkg::PH_SD_LO) begin
                        rd_value_in   = length_ff[7:0];
                        byte_count_in = 16'd0;
                        if (length_ff == 16'd0) begin
                           done = 1'b1;
                        end else begin
                           phase_in = bhml_pkg::PH_SD_BODY;
                        end
                     end else begin
                        rd_value_in   = item.tx_byte;
                        tx_taken_in   = 1'b1;
                        byte_count_in = byte_count_inc;
                        done          = (byte_count_inc >= length_ff);
                     end
                  end
               end
               default: begin
                  // idle: a poll has no effect
               end
            endcase
         end
      endcase

      if (done) begin
         phase_in  = bhml_pkg::PH_IDLE;
         status_in = bhml_pkg::ST_DONE;
      end else if (timeout) begin
         status_in = bhml_pkg::ST_TIMEOUT;
      end else if (phase_in != bhml_pkg::PH_IDLE) begin
         status_in = bhml_pkg::ST_BUSY;
      end

      rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backoff_polls_ff <= bhml_pkg::BACKOFF_POLLS_RESET;
         bail_limit_ff    <= bhml_pkg::BAIL_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            bhml_pkg::REG_BACKOFF_POLLS: backoff_polls_ff <= csr_wdata[15:0];
            bhml_pkg::REG_BAIL_LIMIT:    bail_limit_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= bhml_pkg::PH_IDLE;
         last_sync_ff    <= 8'd0;
         backoff_left_ff <= 16'd0;
         bail_count_ff   <= 8'd0;
         length_ff       <= 16'd0;
         byte_count_ff   <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff        <= phase_in;
            last_sync_ff    <= last_sync_in;
            backoff_left_ff <= backoff_left_in;
            bail_count_ff   <= bail_count_in;
            length_ff       <= length_in;
            byte_count_ff   <= byte_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rc_write_ff   <= rc_write_in;
         rc_value_ff   <= rc_value_in;
         rd_write_ff   <= rd_write_in;
         rd_value_ff   <= rd_value_in;
         rx_valid_ff   <= rx_valid_in;
         rx_byte_ff    <= rx_byte_in;
         tx_taken_ff   <= tx_taken_in;
         status_ff     <= status_in;
         msg_length_ff <= length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rc_write   = rc_write_ff;
   assign rsp_rc_value   = rc_value_ff;
   assign rsp_rd_write   = rd_write_ff;
   assign rsp_rd_value   = rd_value_ff;
   assign rsp_rx_valid   = rx_valid_ff;
   assign rsp_rx_byte    = rx_byte_ff;
   assign rsp_tx_taken   = tx_taken_ff;
   assign rsp_status     = status_ff;
   assign rsp_msg_length = msg_length_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/byte_handshake_message_link_unit.sv -----
// Top level of the byte handshake message link responder.
//
//   channel   ports   direction   handshake
//   request   req_*   in          req_valid / req_stall
//   result    rsp_*   out         rsp_valid / rsp_stall
//   config    csr_*   in          csr_write_en, no wait
//
// One item per clock sustained while rsp_stall is low; an item's result is on rsp_valid after
// the queue slot and then the engine's result register.
// The engine runs one item per cycle whenever its result register is free or drains.
// req_stall rises only when the queue of QUEUE_DEPTH items is full.
// Synchronous reset clears the queue and the link state and loads the config registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none
module byte_handshake_message_link_unit #(
   parameter int QUEUE_DEPTH = bhml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [bhml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bhml_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [7:0]                       req_tc_value,
   input  wire logic [7:0]                       req_td_value,
   input  wire logic [7:0]                       req_tx_byte,
   input  wire logic [15:0]                      req_send_length,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_rc_write,
   output logic [7:0]                            rsp_rc_value,
   output logic                                  rsp_rd_write,
   output logic [7:0]                            rsp_rd_value,
   output logic                                  rsp_rx_valid,
   output logic [7:0]                            rsp_rx_byte,
   output logic                                  rsp_tx_taken,
   output logic [1:0]                            rsp_status,
   output logic [15:0]                           rsp_msg_length
);

   logic                    queue_full;
   logic                    queue_push;
   bhml_pkg::bhml_item_type push_item;
   logic                    queue_pop;
   logic                    queue_valid;
   bhml_pkg::bhml_item_type pop_item;

   bhml_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_tc_value    (req_tc_value),
      .req_td_value    (req_td_value),
      .req_tx_byte     (req_tx_byte),
      .req_send_length (req_send_length),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_item      (push_item)
   );

   bhml_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_item  (pop_item)
   );

   bhml_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .item_valid     (queue_valid),
      .item           (pop_item),
      .item_pop       (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rc_write   (rsp_rc_write),
      .rsp_rc_value   (rsp_rc_value),
      .rsp_rd_write   (rsp_rd_write),
      .rsp_rd_value   (rsp_rd_value),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_tx_taken   (rsp_tx_taken),
      .rsp_status     (rsp_status),
      .rsp_msg_length (rsp_msg_length)
   );

endmodule
`default_nettype wire
